// ----- rtl/core/srs_pkg.sv -----
// Package for the spectrometer readout sequencer: sequence phase type,
// field widths and default sequence lengths.
// No dependencies.
package srs_pkg;

   localparam int CHANNELS_DEFAULT      = 288;
   localparam int SETTLE_CLOCKS_DEFAULT = 85;
   localparam int TAIL_CLOCKS_DEFAULT   = 7;
   localparam int SAMPLE_BITS_DEFAULT   = 16;

   localparam int PERIOD_BITS        = 20;
   localparam int INTEG_BITS         = 20;
   localparam int SAMPLE_FIELD_BITS  = 16;
   localparam int CHANNEL_INDEX_BITS = 9;
   localparam int CSR_ADDR_BITS      = 3;
   localparam int CSR_DATA_BITS      = 32;

   // Register word indexes on the configuration port.
   localparam logic REG_INTEG_SETTING     = 1'b0;
   localparam logic REG_FLUSH_PASS_ENABLE = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_START  = 3'd1,
      PH_INTEG  = 3'd2,
      PH_SETTLE = 3'd3,
      PH_READ   = 3'd4,
      PH_TAIL   = 3'd5,
      PH_FINAL  = 3'd6
   } phase_type;

endpackage

// ----- rtl/core/spectrometer_readout_sequencer.sv -----
// Readout sequencer for a linear spectral sensor: one request per half clock
// tick, one response per request. Depends on srs_pkg.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata: start_request, video_sample
//   rsp      out        rsp_tvalid/rsp_tready  tdata: levels, sample, busy;
//                                              tlast: last_sample; tuser: final_pass
//   csr      in/out     APB, pready tied high  integration setting, flush_pass_enable
//
// For each request the phase counters and the response are computed from the state
// registers and the request in one pass and registered together.
// A new request is taken every cycle while the response register is empty or
// being drained; a stalled response holds off further requests.
// Reset is synchronous and returns the sequencer to idle with both lines low.
module spectrometer_readout_sequencer
   import srs_pkg::*;
#(
   parameter int CHANNELS      = CHANNELS_DEFAULT,
   parameter int SETTLE_CLOCKS = SETTLE_CLOCKS_DEFAULT,
   parameter int TAIL_CLOCKS   = TAIL_CLOCKS_DEFAULT,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [0] start_request, [16:1] video_sample, [23:17] zero
   input  logic [23:0]              req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [0] clock_level, [1] start_level, [2] sample_valid, [18:3] sample_value,
   // [27:19] channel_index, [28] busy_res, [31:29] zero
   output logic [31:0]              rsp_tdata,
   output logic                     rsp_tlast,
   // [0] final_pass
   output logic                     rsp_tuser,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int CC_BITS = $clog2(CHANNELS + 1);
   localparam logic [SAMPLE_FIELD_BITS-1:0] SAMPLE_MASK =
      SAMPLE_FIELD_BITS'((33'd1 << SAMPLE_BITS) - 33'd1);
   localparam logic [PERIOD_BITS-1:0] SETTLE_COUNT = PERIOD_BITS'(SETTLE_CLOCKS);
   localparam logic [PERIOD_BITS-1:0] READ_COUNT   = PERIOD_BITS'(CHANNELS + 1);
   localparam logic [PERIOD_BITS-1:0] TAIL_COUNT   = PERIOD_BITS'(TAIL_CLOCKS);
   localparam logic [CC_BITS-1:0]     CC_END       = CC_BITS'(CHANNELS);
   localparam logic [CC_BITS-1:0]     CC_LAST      = CC_BITS'(CHANNELS - 1);

   // Configuration registers.
   logic [INTEG_BITS-1:0] integ_setting_ff;
   logic                  flush_pass_enable_ff;

   // Sequencer state.
   phase_type             phase_ff, phase_in;
   logic [PERIOD_BITS-1:0] period_count_ff, period_count_in;
   logic                  half_period_ff, half_period_in;
   logic [CC_BITS-1:0]    channel_count_ff, channel_count_in;
   logic                  pass_flag_ff, pass_flag_in;
   logic                  clock_out_ff, clock_out_in;
   logic                  start_out_ff, start_out_in;

   // Response register.
   logic                          rsp_valid_ff;
   logic                          sample_valid_ff, sample_valid_in;
   logic [SAMPLE_FIELD_BITS-1:0]  sample_value_ff, sample_value_in;
   logic [CHANNEL_INDEX_BITS-1:0] channel_index_ff, channel_index_in;
   logic                          last_sample_ff, last_sample_in;
   logic                          final_pass_ff, final_pass_in;
   logic                          busy_ff, busy_in;

   logic                          start_request;
   logic [SAMPLE_FIELD_BITS-1:0]  video_sample;
   logic                          req_fire;
   logic                          csr_write;
   logic [PERIOD_BITS-1:0]        integ_periods;
   logic [PERIOD_BITS-1:0]        period_dec;

   assign start_request = req_tdata[0];
   assign video_sample  = req_tdata[SAMPLE_FIELD_BITS:1];
   assign req_tready    = !rsp_valid_ff || rsp_tready;
   assign req_fire      = req_tvalid && req_tready;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[2])
         REG_INTEG_SETTING:     csr_prdata = CSR_DATA_BITS'(integ_setting_ff);
         REG_FLUSH_PASS_ENABLE: csr_prdata = CSR_DATA_BITS'(flush_pass_enable_ff);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_setting_ff     <= '0;
         flush_pass_enable_ff <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_INTEG_SETTING:     integ_setting_ff     <= csr_pwdata[INTEG_BITS-1:0];
            REG_FLUSH_PASS_ENABLE: flush_pass_enable_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   assign integ_periods = PERIOD_BITS'(integ_setting_ff >> 1);

   always_comb begin
      phase_in         = phase_ff;
      period_count_in  = period_count_ff;
      half_period_in   = half_period_ff;
      channel_count_in = channel_count_ff;
      pass_flag_in     = pass_flag_ff;
      clock_out_in     = clock_out_ff;
      start_out_in     = start_out_ff;
      busy_in          = 1'b1;
      sample_valid_in  = 1'b0;
      sample_value_in  = '0;
      channel_index_in = '0;
      last_sample_in   = 1'b0;
      final_pass_in    = 1'b0;
      period_dec       = '0;

      // A start request taken while idle makes this tick the first of the start phase.
      if (phase_ff == PH_IDLE) begin
         if (start_request) begin
            pass_flag_in     = !flush_pass_enable_ff;
            phase_in         = PH_START;
            period_count_in  = '0;
            half_period_in   = 1'b0;
            channel_count_in = '0;
         end else begin
            busy_in = 1'b0;
         end
      end

      unique case (phase_in)
         PH_IDLE: ;
         PH_START: begin
            clock_out_in = (period_count_in == PERIOD_BITS'(1));
            start_out_in = (period_count_in == PERIOD_BITS'(2)) ? 1'b1 : start_out_ff;
            if (period_count_in >= PERIOD_BITS'(2)) begin
               half_period_in = 1'b0;
               if (pass_flag_in && integ_periods != '0) begin
                  phase_in        = PH_INTEG;
                  period_count_in = integ_periods;
               end else begin
                  phase_in        = PH_SETTLE;
                  period_count_in = SETTLE_COUNT;
               end
            end else begin
               period_count_in = period_count_in + PERIOD_BITS'(1);
            end
         end
         PH_INTEG, PH_SETTLE, PH_READ, PH_TAIL: begin
            clock_out_in = !half_period_in;
            start_out_in = (phase_in == PH_INTEG) || (phase_in == PH_TAIL);
            // Channels are captured on the low half, before the rising edge.
            if (phase_in == PH_READ && half_period_in && channel_count_in < CC_END) begin
               sample_valid_in  = 1'b1;
               sample_value_in  = video_sample & SAMPLE_MASK;
               channel_index_in = CHANNEL_INDEX_BITS'(channel_count_in);
               last_sample_in   = (channel_count_in == CC_LAST);
               final_pass_in    = pass_flag_in;
               channel_count_in = channel_count_in + CC_BITS'(1);
            end
            if (half_period_in) begin
               period_dec = (period_count_in != '0) ? period_count_in - PERIOD_BITS'(1)
                                                    : period_count_in;
               period_count_in = period_dec;
               if (period_dec == '0) begin
                  unique case (phase_in)
                     PH_INTEG: begin
                        phase_in        = PH_SETTLE;
                        period_count_in = SETTLE_COUNT;
                     end
                     PH_SETTLE: begin
                        phase_in         = PH_READ;
                        period_count_in  = READ_COUNT;
                        channel_count_in = '0;
                     end
                     PH_READ: begin
                        phase_in        = PH_TAIL;
                        period_count_in = TAIL_COUNT;
                     end
                     default: phase_in = PH_FINAL;
                  endcase
               end
            end
            half_period_in = !half_period_in;
         end
         PH_FINAL: begin
            clock_out_in = 1'b1;
            start_out_in = 1'b1;
            // After the flush pass the integrating pass follows at once.
            if (!pass_flag_in) begin
               pass_flag_in     = 1'b1;
               phase_in         = PH_START;
               period_count_in  = '0;
               half_period_in   = 1'b0;
               channel_count_in = '0;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         period_count_ff  <= '0;
         half_period_ff   <= 1'b0;
         channel_count_ff <= '0;
         pass_flag_ff     <= 1'b0;
         clock_out_ff     <= 1'b0;
         start_out_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else if (req_fire) begin
         phase_ff         <= phase_in;
         period_count_ff  <= period_count_in;
         half_period_ff   <= half_period_in;
         channel_count_ff <= channel_count_in;
         pass_flag_ff     <= pass_flag_in;
         clock_out_ff     <= clock_out_in;
         start_out_ff     <= start_out_in;
         rsp_valid_ff     <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_valid_ff  <= sample_valid_in;
         sample_value_ff  <= sample_value_in;
         channel_index_ff <= channel_index_in;
         last_sample_ff   <= last_sample_in;
         final_pass_ff    <= final_pass_in;
         busy_ff          <= busy_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, busy_ff, channel_index_ff, sample_value_ff,
                        sample_valid_ff, start_out_ff, clock_out_ff};
   assign rsp_tlast  = last_sample_ff;
   assign rsp_tuser  = final_pass_ff;

endmodule
